[rtl/core/dts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared widths, depths and types of the dependency ordering block.
// ----------------------------------------------------------------------------
package dts_pkg;

	localparam int NODE_W  = 5;              // node index
	localparam int ROWS    = 32;             // row store depth
	localparam int MASK_W  = 32;             // dependency row width
	localparam int COUNT_W = 6;              // counts that reach ROWS
	localparam int STACK_W = COUNT_W + NODE_W;

	// One saved path entry: node and the column to resume at.
	typedef struct packed {
		logic [COUNT_W-1:0] col;
		logic [NODE_W-1:0]  node;
	} stack_entry_t;

	// Decision for the node on top of the path in one step.
	typedef struct packed {
		logic              place;   // node is finished, place it and pop
		logic              push;    // descend into col
		logic              cycle;   // dependency found on the current path
		logic [NODE_W-1:0] col;     // selected dependency
	} scan_t;

endpackage

[rtl/core/dts_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/dts_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_scan
// Picks the next unplaced dependency of the top path node at or above the
// resume column and decides between descending and placing the node.
// ----------------------------------------------------------------------------
module dts_scan (
	input  logic [dts_pkg::MASK_W-1:0]  deps,
	input  logic [dts_pkg::MASK_W-1:0]  placed,
	input  logic [dts_pkg::MASK_W-1:0]  on_path,
	input  logic [dts_pkg::COUNT_W-1:0] col,
	input  logic                        unwind,
	output dts_pkg::scan_t              scan
);
	import dts_pkg::*;

	logic [MASK_W-1:0] cand;
	logic              found;
	logic [NODE_W-1:0] pick;
	logic              hit;

	always_comb begin
		for (int j = 0; j < MASK_W; j++) begin
			cand[j] = deps[j] & ~placed[j] & (COUNT_W'(j) >= col);
		end
	end

	// lowest set candidate wins
	always_comb begin
		pick = '0;
		for (int j = MASK_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				pick = NODE_W'(j);
			end
		end
	end

	assign found = |cand;
	assign hit   = on_path[pick];

	always_comb begin
		scan.cycle = !unwind && found && hit;
		scan.place = unwind || !found || hit;
		scan.push  = !scan.place;
		scan.col   = pick;
	end

endmodule

[rtl/core/dependency_topological_sort_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_topological_sort_unit
// Depth-first topological ordering of up to 32 dependency rows.
// ----------------------------------------------------------------------------
// Each input item is one node's dependency row; rows are stored in a RAM as
// they are accepted. Extra rows beyond the capacity are dropped and flagged.
// The item with tlast starts the walk, which runs with the input closed: each
// step on the top path node picks its next dependency (lowest unplaced
// column); a descent is followed by a row RAM read, and a return to the parent
// by a path stack RAM read, then a row RAM read. The order is then sent out of
// the order RAM one item at a time, each read, registered and held until taken
// before the next is read; cycle and overflow flags ride on the last item.
// After the last result is taken the block is empty and accepts a new batch.
// ----------------------------------------------------------------------------
module dependency_topological_sort_unit #(
	parameter int MAX_NODES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] dep_mask
	input  logic        s_tlast,   // last_row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [4:0] node_index, [7:5] zero
	output logic        m_tlast,   // last_out
	output logic [1:0]  m_tuser    // [0] cycle_found, [1] overflow
);
	import dts_pkg::*;

	localparam int CAPACITY = (MAX_NODES < ROWS) ? MAX_NODES : ROWS;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROOT,
		ST_FETCH,
		ST_SCAN,
		ST_POP,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] rows_q;
	logic [COUNT_W-1:0] root_q;
	logic [COUNT_W-1:0] sp_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] emit_q;
	logic [MASK_W-1:0]  placed_q;
	logic [MASK_W-1:0]  on_path_q;
	logic [MASK_W-1:0]  deps_q;
	logic [NODE_W-1:0]  node_q;
	logic [COUNT_W-1:0] col_q;
	logic               unwind_q;
	logic               cycle_q;
	logic               ovf_q;

	logic [MASK_W-1:0]  valid_cols;
	scan_t              scan;
	stack_entry_t       push_entry;
	stack_entry_t       pop_entry;
	logic [STACK_W-1:0] stack_rdata;
	logic [MASK_W-1:0]  adj_rdata;
	logic [NODE_W-1:0]  adj_raddr;
	logic [NODE_W-1:0]  order_rdata;
	logic               in_acc;
	logic               adj_we;
	logic               push_we;
	logic               place_we;
	logic               fin;

	assign in_acc   = s_tvalid && s_tready;
	assign adj_we   = in_acc && (rows_q < COUNT_W'(CAPACITY));
	assign push_we  = (state_q == ST_SCAN) && scan.push;
	assign place_we = (state_q == ST_SCAN) && scan.place;
	assign s_tready = (state_q == ST_LOAD);
	assign fin      = (emit_q + COUNT_W'(1)) == cnt_q;

	always_comb begin
		for (int j = 0; j < MASK_W; j++) begin
			valid_cols[j] = COUNT_W'(j) < rows_q;
		end
	end

	assign pop_entry       = stack_entry_t'(stack_rdata);
	assign push_entry.node = node_q;
	assign push_entry.col  = COUNT_W'(scan.col) + COUNT_W'(1);

	always_comb begin
		unique case (state_q)
			ST_ROOT: adj_raddr = root_q[NODE_W-1:0];
			ST_POP:  adj_raddr = pop_entry.node;
			default: adj_raddr = scan.col;
		endcase
	end

	dts_ram #(.WIDTH(MASK_W), .DEPTH(ROWS)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (rows_q[NODE_W-1:0]),
		.wdata (s_tdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Push writes at sp-1 and pop reads at sp-2 in different steps; the pop
	// data is consumed one state later, so no forwarding is needed.
	dts_ram #(.WIDTH(STACK_W), .DEPTH(ROWS)) u_stack (
		.clk   (clk),
		.we    (push_we),
		.waddr (NODE_W'(sp_q - COUNT_W'(1))),
		.wdata (push_entry),
		.raddr (NODE_W'(sp_q - COUNT_W'(2))),
		.rdata (stack_rdata)
	);

	dts_ram #(.WIDTH(NODE_W), .DEPTH(ROWS)) u_order (
		.clk   (clk),
		.we    (place_we),
		.waddr (cnt_q[NODE_W-1:0]),
		.wdata (node_q),
		.raddr (emit_q[NODE_W-1:0]),
		.rdata (order_rdata)
	);

	dts_scan u_scan (
		.deps    (deps_q),
		.placed  (placed_q),
		.on_path (on_path_q),
		.col     (col_q),
		.unwind  (unwind_q),
		.scan    (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			rows_q    <= '0;
			root_q    <= '0;
			sp_q      <= '0;
			cnt_q     <= '0;
			emit_q    <= '0;
			placed_q  <= '0;
			on_path_q <= '0;
			deps_q    <= '0;
			node_q    <= '0;
			col_q     <= '0;
			unwind_q  <= 1'b0;
			cycle_q   <= 1'b0;
			ovf_q     <= 1'b0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tlast   <= 1'b0;
			m_tuser   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (adj_we) begin
							rows_q <= rows_q + COUNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							root_q  <= '0;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (root_q >= rows_q) begin
						emit_q  <= '0;
						state_q <= ST_EMIT_RD;
					end else if (placed_q[root_q[NODE_W-1:0]]) begin
						root_q <= root_q + COUNT_W'(1);
					end else begin
						node_q    <= root_q[NODE_W-1:0];
						col_q     <= '0;
						sp_q      <= COUNT_W'(1);
						unwind_q  <= 1'b0;
						on_path_q <= on_path_q | (MASK_W'(1) << root_q[NODE_W-1:0]);
						state_q   <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					deps_q  <= adj_rdata & valid_cols & ~(MASK_W'(1) << node_q);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan.cycle) begin
						cycle_q  <= 1'b1;
						unwind_q <= 1'b1;
					end
					if (scan.push) begin
						node_q    <= scan.col;
						col_q     <= '0;
						sp_q      <= sp_q + COUNT_W'(1);
						on_path_q <= on_path_q | (MASK_W'(1) << scan.col);
						state_q   <= ST_FETCH;
					end else begin
						cnt_q     <= cnt_q + COUNT_W'(1);
						placed_q  <= placed_q | (MASK_W'(1) << node_q);
						on_path_q <= on_path_q & ~(MASK_W'(1) << node_q);
						sp_q      <= sp_q - COUNT_W'(1);
						if (sp_q == COUNT_W'(1)) begin
							root_q  <= root_q + COUNT_W'(1);
							state_q <= ST_ROOT;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					node_q  <= pop_entry.node;
					col_q   <= pop_entry.col;
					state_q <= ST_FETCH;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					m_tvalid <= 1'b1;
					m_tdata  <= {3'b000, order_rdata};
					m_tlast  <= fin;
					m_tuser  <= fin ? {ovf_q, cycle_q} : 2'b00;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (fin) begin
							rows_q    <= '0;
							cnt_q     <= '0;
							emit_q    <= '0;
							placed_q  <= '0;
							on_path_q <= '0;
							cycle_q   <= 1'b0;
							ovf_q     <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							emit_q  <= emit_q + COUNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// input is closed whenever a result is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input open while a result is pending");

	// flags only travel on the final item of the order
	a_flags_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == 2'b00))
		else $error("flags set on a non-final item");

	// every placed node comes from a loaded row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= rows_q) && (rows_q <= COUNT_W'(CAPACITY)))
		else $error("placed count beyond loaded rows");

	// a node being placed is on the path and not yet placed
	a_place_state: assert property (@(posedge clk) disable iff (!arst_n)
		place_we |-> (on_path_q[node_q] && !placed_q[node_q]))
		else $error("placing a node off the path or twice");

endmodule

[tb/sv/tb_dependency_topological_sort_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dependency_topological_sort_unit
// Self-checking bench for the depth-first dependency ordering block.
// ----------------------------------------------------------------------------
// Dependency rows are streamed in as batches that end with tlast. A behavioral
// copy of the walk computes the order of each batch when its last row is taken,
// and every result item is checked in turn against it. The stimulus covers
// directed chains, cycles, self bits and bits beyond the batch, then random
// batches of mixed shape, with full and overflowing batches among them. The
// sender idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_dependency_topological_sort_unit;
	import dts_pkg::*;

	localparam int CAPACITY  = ROWS;
	localparam int MAX_SHOW  = 10;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              last;
		logic              hold;   // wait until the block has drained
	} row_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              last;
		logic              cycle;
		logic              ovf;
	} order_item_t;

	typedef enum int {
		MASK_RANDOM, MASK_LOWER, MASK_HIGHER, MASK_SPARSE, MASK_ALL, MASK_NONE
	} mask_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	dependency_topological_sort_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	row_item_t   pending_rows[$];
	order_item_t expected_order[$];

	// behavioral copy of the block state
	logic [MASK_W-1:0] row_store[CAPACITY];
	int                rows_held;
	bit                rows_dropped;

	int  mismatches;
	int  results_seen;
	int  rows_sent;
	int  batches_sorted;
	int  cycle_batches;
	int  overflow_batches;
	bit  row_taken;
	int  gap_left;
	int  burst_left;
	int  rx_cyc;

	// Depth-first walk over the stored rows; appends the expected order.
	task automatic sort_batch();
		logic [MASK_W-1:0] valid_cols;
		logic [MASK_W-1:0] done;
		logic [MASK_W-1:0] on_path;
		logic [MASK_W-1:0] deps;
		logic [NODE_W-1:0] stk_node[CAPACITY];
		int                stk_col[CAPACITY];
		logic [NODE_W-1:0] placed[$];
		order_item_t       item;
		int                len;
		int                sp;
		int                n;
		bit                unwind;
		bit                pushed;
		bit                loop_found;

		len = rows_held;
		valid_cols = (len >= 32) ? '1 : ((32'h1 << len) - 1);
		done = '0;
		on_path = '0;
		loop_found = 1'b0;
		for (int root = 0; root < len; root++) begin
			if (done[root])
				continue;
			stk_node[0] = root[NODE_W-1:0];
			stk_col[0] = 0;
			sp = 1;
			on_path[root] = 1'b1;
			unwind = 1'b0;
			while (sp > 0) begin
				n = stk_node[sp-1];
				deps = row_store[n] & valid_cols;
				deps[n] = 1'b0;
				pushed = 1'b0;
				if (!unwind) begin
					for (int k = stk_col[sp-1]; k < len; k++) begin
						if (!deps[k] || done[k])
							continue;
						if (on_path[k]) begin
							// back edge: stop this branch, ancestors unwind too
							loop_found = 1'b1;
							unwind = 1'b1;
							break;
						end
						stk_col[sp-1] = k + 1;
						if (sp < CAPACITY) begin
							stk_node[sp] = k[NODE_W-1:0];
							stk_col[sp] = 0;
							sp++;
							on_path[k] = 1'b1;
							pushed = 1'b1;
						end
						break;
					end
				end
				if (pushed)
					continue;
				placed.push_back(n[NODE_W-1:0]);
				done[n] = 1'b1;
				on_path[n] = 1'b0;
				sp--;
			end
		end
		foreach (placed[i]) begin
			item.node  = placed[i];
			item.last  = (i == placed.size() - 1);
			item.cycle = item.last & loop_found;
			item.ovf   = item.last & rows_dropped;
			expected_order.push_back(item);
		end
		batches_sorted++;
		if (loop_found)
			cycle_batches++;
		if (rows_dropped)
			overflow_batches++;
		rows_held = 0;
		rows_dropped = 1'b0;
	endtask

	task automatic take_row(input logic [MASK_W-1:0] mask, input logic last);
		if (rows_held < CAPACITY) begin
			row_store[rows_held] = mask;
			rows_held++;
		end else begin
			rows_dropped = 1'b1;
		end
		rows_sent++;
		if (last)
			sort_batch();
	endtask

	function automatic logic [MASK_W-1:0] make_mask(input mask_style_t style, input int idx);
		int i;

		i = idx % 32;
		case (style)
			MASK_LOWER:  return $urandom & ((32'h1 << i) - 1);
			MASK_HIGHER: return $urandom & ~((32'h2 << i) - 1);
			MASK_SPARSE: return $urandom & $urandom & $urandom;
			MASK_ALL:    return '1;
			MASK_NONE:   return '0;
			default:     return $urandom;
		endcase
	endfunction

	task automatic push_row(input logic [MASK_W-1:0] mask, input logic last, input logic hold);
		row_item_t r;

		r.mask = mask;
		r.last = last;
		r.hold = hold;
		pending_rows.push_back(r);
	endtask

	task automatic add_random_batch(input int nrows, input bit hold);
		mask_style_t style;

		style = mask_style_t'($urandom_range(MASK_RANDOM, MASK_NONE));
		// all-ones and empty batches are rare, the other shapes common
		if ((style == MASK_ALL || style == MASK_NONE) && $urandom_range(0, 2) != 0)
			style = MASK_SPARSE;
		for (int i = 0; i < nrows; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_row(make_mask(mask_style_t'($urandom_range(MASK_RANDOM, MASK_NONE)), i),
					i == nrows - 1, hold && i == 0);
			else
				push_row(make_mask(style, i), i == nrows - 1, hold && i == 0);
		end
	endtask

	// stimulus
	initial begin
		int random_rows;
		int nb;
		int nrows;

		// single rows: empty, and all bits (self and beyond the batch ignored)
		push_row(32'h0000_0000, 1'b1, 1'b0);
		push_row(32'hFFFF_FFFF, 1'b1, 1'b0);
		// reverse chain: 0 needs 1 needs 2 needs 3
		push_row(32'h0000_0002, 1'b0, 1'b0);
		push_row(32'h0000_0004, 1'b0, 1'b0);
		push_row(32'h0000_0008, 1'b0, 1'b0);
		push_row(32'h8000_0000, 1'b1, 1'b0);
		// three-node cycle
		push_row(32'h0000_0002, 1'b0, 1'b0);
		push_row(32'h0000_0004, 1'b0, 1'b0);
		push_row(32'h0000_0001, 1'b1, 1'b0);
		// self bits and a dependency already placed
		push_row(32'h0000_0005, 1'b0, 1'b0);
		push_row(32'h0000_0006, 1'b0, 1'b0);
		push_row(32'h0000_0004, 1'b1, 1'b0);
		// cycle in the first root; skipped dependency placed by a later root
		push_row(32'h0000_000A, 1'b0, 1'b0);
		push_row(32'h0000_0001, 1'b0, 1'b0);
		push_row(32'h0000_0000, 1'b0, 1'b0);
		push_row(32'h0000_0004, 1'b1, 1'b0);
		// every node depends on every node
		push_row(32'hFFFF_FFFF, 1'b0, 1'b1);
		push_row(32'hFFFF_FFFF, 1'b0, 1'b0);
		push_row(32'hFFFF_FFFF, 1'b0, 1'b0);
		push_row(32'hFFFF_FFFF, 1'b1, 1'b0);

		random_rows = 0;
		nb = 0;
		while (random_rows < 150) begin
			if (nb == 1)
				nrows = CAPACITY;
			else if (nb == 4)
				nrows = CAPACITY + 3;
			else if ($urandom_range(0, 11) == 0)
				nrows = $urandom_range(CAPACITY - 2, CAPACITY + 4);
			else
				nrows = $urandom_range(1, 8);
			add_random_batch(nrows, nb == 0 || $urandom_range(0, 9) == 0);
			random_rows += nrows;
			nb++;
		end
	end

	// reset and input defaults
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// sender: bursts of rows with random gaps
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !row_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_rows.size() > 0 &&
					!(pending_rows[0].hold && expected_order.size() > 0)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_rows[0].mask;
				s_tlast  <= pending_rows[0].last;
				void'(pending_rows.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: free flow, random stalls, sparse accepts, light stalls
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cyc <= rx_cyc + 1;
			case ((rx_cyc / 256) % 4)
				0:       m_tready <= 1'b1;
				1:       m_tready <= $urandom_range(0, 1);
				2:       m_tready <= (rx_cyc % 5 == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// row capture, prediction and result check
	always @(posedge clk) begin
		order_item_t want;

		if (arst_n) begin
			row_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				take_row(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_order.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOW)
						$display("%t: unexpected item node=%0d last=%0b user=%b",
							$realtime, m_tdata, m_tlast, m_tuser);
				end else begin
					want = expected_order.pop_front();
					if (m_tdata !== {3'b000, want.node} || m_tlast !== want.last ||
							m_tuser[0] !== want.cycle || m_tuser[1] !== want.ovf) begin
						mismatches++;
						if (mismatches <= MAX_SHOW) begin
							$display("%t: mismatch exp node=%0d last=%0b cyc=%0b ovf=%0b",
								$realtime, want.node, want.last, want.cycle, want.ovf);
							$display("%t:          got tdata=%0d last=%0b cyc=%0b ovf=%0b",
								$realtime, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
						end
					end
				end
			end
		end
	end

	initial begin
		mismatches       = 0;
		results_seen     = 0;
		rows_sent        = 0;
		batches_sorted   = 0;
		cycle_batches    = 0;
		overflow_batches = 0;
		rows_held        = 0;
		rows_dropped     = 1'b0;
		row_taken        = 1'b0;
		gap_left         = 0;
		burst_left       = 1;
		rx_cyc           = 0;
	end

	// end of run
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (pending_rows.size() != 0 || s_tvalid || expected_order.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (expected_order.size() != 0)
			mismatches++;
		$display("rows sent %0d in %0d batches, %0d items checked", rows_sent,
			batches_sorted, results_seen);
		$display("batches with a cycle %0d, with dropped rows %0d", cycle_batches,
			overflow_batches);
		if (mismatches == 0) begin
			$display("tb_dependency_topological_sort_unit: PASS");
		end else begin
			$display("mismatches: %0d", mismatches);
			$display("tb_dependency_topological_sort_unit: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout: %0d items still expected", expected_order.size());
		$display("tb_dependency_topological_sort_unit: FAIL");
		$finish;
	end

endmodule
